>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and error codes for the double-ended queue.
// No dependencies; imported by dq_cell, double_ended_queue and double_ended_queue_test.
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef logic [2:0] op_t;
  typedef logic [1:0] err_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam op_t OP_PUSH_FRONT  = 3'd0;
  localparam op_t OP_PUSH_BACK   = 3'd1;
  localparam op_t OP_POP_FRONT   = 3'd2;
  localparam op_t OP_POP_BACK    = 3'd3;
  localparam op_t OP_WRITE_FRONT = 3'd4;
  localparam op_t OP_WRITE_BACK  = 3'd5;
  localparam op_t OP_CLEAR       = 3'd6;
  localparam op_t OP_READ        = 3'd7;

  localparam err_t ERR_OK        = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNDERFLOW = 2'd2;

  typedef struct packed {
    op_t   op;
    word_t value;
  } in_t;

  typedef struct packed {
    word_t              front_value;
    word_t              back_value;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    err_t               error;
  } out_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic en;
    op_t  op;
  } dq_cmd_t;

endpackage

>>> rtl/dq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue row: a word and its valid bit.
// Depends on dq_pkg; instantiated DEPTH times by double_ended_queue.
module dq_cell import dq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dq_cmd_t cmd,
  input  word_t   value,
  input  logic    head,
  input  word_t   left_data,
  input  logic    left_valid,
  input  word_t   right_data,
  input  logic    right_valid,
  output word_t   data,
  output logic    valid,
  output word_t   back_data
);

  word_t data_r, data_nxt;
  logic  valid_r, valid_nxt;
  logic  is_last;

  assign is_last = valid_r & ~right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      unique case (cmd.op)
        OP_PUSH_FRONT: begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
        OP_PUSH_BACK: begin
          // first free slot takes the beat
          if (!valid_r && left_valid) begin
            data_nxt  = value;
            valid_nxt = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
        OP_POP_BACK: begin
          if (is_last) valid_nxt = 1'b0;
        end
        OP_WRITE_FRONT: begin
          if (head && valid_r) data_nxt = value;
        end
        OP_WRITE_BACK: begin
          if (is_last) data_nxt = value;
        end
        OP_CLEAR: begin
          valid_nxt = 1'b0;
        end
        OP_READ: begin
          valid_nxt = valid_r;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign valid     = valid_r;
  assign back_data = is_last ? data_r : '0;

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded double-ended queue built as a row of shifting cells, front at cell 0.
// An accepted beat sets calc_r for the build cycle, and out_valid is registered from it.
// The input stalls through the build cycle and until the result beat is taken, so no new
// beat is accepted before the last result is taken. Reset empties the queue (valid bits and
// count cleared); stored words are not cleared. Depends on dq_pkg and dq_cell.
module double_ended_queue import dq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic             calc_r, calc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  err_t             err_r, err_nxt;
  out_t             out_r, out_nxt;

  logic    accept, full, empty, legal;
  dq_cmd_t cmd;

  word_t cell_data  [DEPTH];
  word_t back_data  [DEPTH];
  word_t left_data  [DEPTH];
  word_t right_data [DEPTH];
  logic [DEPTH-1:0] cell_valid, left_valid, right_valid;
  word_t back_any;

  assign in_stall = calc_r | out_valid_r;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    legal     = 1'b1;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (accept) begin
      err_nxt = ERR_OK;
      unique case (in_data.op) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            legal   = 1'b0;
            err_nxt = ERR_OVERFLOW;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            legal   = 1'b0;
            err_nxt = ERR_UNDERFLOW;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_WRITE_FRONT, OP_WRITE_BACK: begin
          if (empty) begin
            legal   = 1'b0;
            err_nxt = ERR_UNDERFLOW;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          legal = 1'b1;
        end
      endcase
    end
  end

  assign cmd.en = accept & legal;
  assign cmd.op = in_data.op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i]  = in_data.value;
      assign left_valid[i] = 1'b1;
    end else begin : g_mid
      assign left_data[i]  = cell_data[i-1];
      assign left_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_data[i]  = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner
      assign right_data[i]  = cell_data[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .value       (in_data.value),
      .head        (i == 0),
      .left_data   (left_data[i]),
      .left_valid  (left_valid[i]),
      .right_data  (right_data[i]),
      .right_valid (right_valid[i]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .back_data   (back_data[i])
    );
  end

  // only the last valid cell drives a nonzero word
  always_comb begin
    back_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_any = back_any | back_data[i];
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    calc_nxt      = calc_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (accept) calc_nxt = 1'b1;
    if (calc_r) begin
      calc_nxt             = 1'b0;
      out_valid_nxt        = 1'b1;
      out_nxt.front_value  = cell_valid[0] ? cell_data[0] : '0;
      out_nxt.back_value   = back_any;
      out_nxt.count        = COUNT_W'(count_r);
      out_nxt.is_empty     = empty;
      out_nxt.error        = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      calc_r      <= calc_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("count disagrees with occupied cells");

  a_cells_packed_front: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !cell_valid[0])
    else $error("front cell occupancy wrong");

  a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> calc_r && !out_valid_r)
    else $error("accepted beat did not start result build");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(calc_r && out_valid_r))
    else $error("result build overlaps pending result");

endmodule

>>> tb/double_ended_queue_test.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue: directed corner cases, then biased
// random fill/drain traffic predicted by a ring-store mirror. Depends on dq_pkg.
module double_ended_queue_test import dq_pkg::*; ();

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_e;

  typedef struct {
    in_t beat;
    bit  drain;
  } pending_t;

  typedef struct {
    out_t   result;
    longint stamp;
  } outcome_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic calm      = 1'b0;

  pending_t pending_beats [$];
  outcome_t expected_results [$];

  // Mirror of the queue contents
  word_t ring_words [DEPTH];
  int    ring_head = 0;
  int    ring_tail = 0;
  int    ring_fill = 0;

  int gen_fill  = 0;
  int send_gap  = 0;
  int hold_left = 0;
  int fails     = 0;

  always #5 clk = ~clk;

  double_ended_queue u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic int ring_prev(int idx);
    return (idx + DEPTH - 1) % DEPTH;
  endfunction

  function automatic out_t apply_op(in_t beat);
    out_t res;
    err_t err;
    err = ERR_OK;
    case (beat.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          err = ERR_OVERFLOW;
        end else if (beat.op == OP_PUSH_FRONT) begin
          ring_head = ring_prev(ring_head);
          ring_words[ring_head] = beat.value;
          ring_fill++;
        end else begin
          ring_words[ring_tail] = beat.value;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_WRITE_FRONT, OP_WRITE_BACK: begin
        if (ring_fill == 0) begin
          err = ERR_UNDERFLOW;
        end else begin
          case (beat.op)
            OP_POP_FRONT: begin
              ring_head = (ring_head + 1) % DEPTH;
              ring_fill--;
            end
            OP_POP_BACK: begin
              ring_tail = ring_prev(ring_tail);
              ring_fill--;
            end
            OP_WRITE_FRONT: ring_words[ring_head] = beat.value;
            default: ring_words[ring_prev(ring_tail)] = beat.value;
          endcase
        end
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
      end
      default: ;
    endcase
    res.front_value = (ring_fill == 0) ? word_t'(0) : ring_words[ring_head];
    res.back_value  = (ring_fill == 0) ? word_t'(0) : ring_words[ring_prev(ring_tail)];
    res.count       = ring_fill[COUNT_W-1:0];
    res.is_empty    = (ring_fill == 0);
    res.error       = err;
    return res;
  endfunction

  // Queue a beat for the driver; track occupancy to bias the random mix
  function automatic void queue_beat(op_t op, word_t value, bit drain = 1'b0);
    pending_t p;
    p.beat.op    = op;
    p.beat.value = value;
    p.drain      = drain;
    pending_beats.insert(pending_beats.size(), p);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
      OP_POP_FRONT, OP_POP_BACK:   if (gen_fill > 0) gen_fill--;
      OP_CLEAR:                    gen_fill = 0;
      default: ;
    endcase
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0: return word_t'(32'h8000_0000);
      1: return word_t'(32'h7fff_ffff);
      2: return word_t'(0);
      3: return word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Driver: hold the beat while stalled, otherwise advance or idle
  always @(posedge clk) begin : drive
    outcome_t entry;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      calm <= (pending_beats.size() < 60);
      if (in_valid && !in_stall) begin
        entry.result = apply_op(in_data);
        entry.stamp  = $time;
        expected_results.insert(expected_results.size(), entry);
        pending_beats.delete(0);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_beats[0].drain && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          pending_beats[0].drain = 1'b0;
          in_valid <= 1'b1;
          in_data  <= pending_beats[0].beat;
        end
      end
    end
  end

  // Monitor: stall in bursts, compare each result beat with the oldest prediction
  always @(posedge clk) begin : observe
    outcome_t want;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (rst_n && out_valid && !out_stall) begin
      // an expectation pushed at this very edge cannot be answered yet
      if (expected_results.size() == 0 || expected_results[0].stamp >= $time) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result beat with nothing outstanding: front %0d back %0d count %0d",
                   $time, out_data.front_value, out_data.back_value, out_data.count);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data.front_value !== want.result.front_value ||
            out_data.back_value !== want.result.back_value ||
            out_data.count !== want.result.count ||
            out_data.is_empty !== want.result.is_empty ||
            out_data.error !== want.result.error) begin
          fails++;
          if (fails <= 10)
            $display("%0t: mismatch front %0d/%0d back %0d/%0d count %0d/%0d empty %0d/%0d err %0d/%0d (got/exp)",
                     $time, out_data.front_value, want.result.front_value,
                     out_data.back_value, want.result.back_value,
                     out_data.count, want.result.count,
                     out_data.is_empty, want.result.is_empty,
                     out_data.error, want.result.error);
        end
      end
    end
  end

  initial begin : stimulus
    mode_e mode;
    int    seg_left;
    int    roll;
    op_t   op;
    mode     = MODE_FILL;
    seg_left = 0;

    // empty queue: plain read, refused pops and writes; then push, write and pop at both ends
    queue_beat(OP_READ, pick_value());
    queue_beat(OP_POP_FRONT, pick_value());
    queue_beat(OP_POP_BACK, pick_value());
    queue_beat(OP_WRITE_FRONT, pick_value());
    queue_beat(OP_WRITE_BACK, pick_value());
    queue_beat(OP_PUSH_BACK, word_t'(32'h7fff_ffff));
    queue_beat(OP_PUSH_FRONT, word_t'(32'h8000_0000));
    queue_beat(OP_WRITE_FRONT, word_t'(-1));
    queue_beat(OP_WRITE_BACK, word_t'(0));
    queue_beat(OP_POP_FRONT, pick_value());
    queue_beat(OP_POP_BACK, pick_value());
    // fill to the brim, then overflow at both ends, then clear
    for (int i = 0; i < DEPTH; i++)
      queue_beat((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    queue_beat(OP_PUSH_FRONT, pick_value());
    queue_beat(OP_PUSH_BACK, pick_value());
    queue_beat(OP_CLEAR, pick_value());

    for (int n = 0; n < 850; n++) begin
      if (seg_left == 0) begin
        mode     = mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      if (mode == MODE_FILL && gen_fill == DEPTH && $urandom_range(0, 3) == 0)
        mode = MODE_DRAIN;
      else if (mode == MODE_DRAIN && gen_fill == 0 && $urandom_range(0, 3) == 0)
        mode = MODE_FILL;
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_FILL: begin
          if (roll < 65)      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          else if (roll < 80) op = $urandom_range(0, 1) ? OP_WRITE_FRONT : OP_WRITE_BACK;
          else if (roll < 92) op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
          else                op = OP_READ;
        end
        MODE_DRAIN: begin
          if (roll < 65)      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
          else if (roll < 80) op = $urandom_range(0, 1) ? OP_WRITE_FRONT : OP_WRITE_BACK;
          else if (roll < 92) op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          else                op = OP_READ;
        end
        default: begin
          op = op_t'($urandom_range(0, 7));
          if (op == OP_CLEAR && roll >= 15)
            op = OP_READ;
        end
      endcase
      queue_beat(op, pick_value(), (n == 0 || n == 425));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      fails++;
      $display("%0d predicted results never arrived", expected_results.size());
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
